/* src/crt_pkg.sv */
`timescale 1ns / 1ps
package crt_pkg;

   localparam int CpW    = 21;  // code point width
   localparam int RepW   = 24;  // repeat count width
   localparam int CountW = 5;   // set count register width
   localparam int CsrIdxW = 3;

   // item functions
   localparam logic [1:0] FUNC_LOAD_SET1  = 2'd0;
   localparam logic [1:0] FUNC_LOAD_SET2  = 2'd1;
   localparam logic [1:0] FUNC_TRANSLATE  = 2'd2;

   // register indexes
   localparam logic [CsrIdxW-1:0] CSR_COMPLEMENT = 3'd0;
   localparam logic [CsrIdxW-1:0] CSR_DELETE     = 3'd1;
   localparam logic [CsrIdxW-1:0] CSR_SQUEEZE    = 3'd2;
   localparam logic [CsrIdxW-1:0] CSR_SET1_COUNT = 3'd3;
   localparam logic [CsrIdxW-1:0] CSR_SET2_COUNT = 3'd4;

   typedef struct packed {
      logic [CpW-1:0] first;
      logic [CpW-1:0] last;
   } span_type;

   typedef struct packed {
      span_type        bounds;
      logic [RepW-1:0] rep;
   } entry_type;

   // length of an inclusive range, zero when inverted
   function automatic logic [CpW:0] span_len(input span_type s);
      logic [CpW:0] len;
      if (s.last >= s.first) begin
         len = {1'b0, s.last - s.first} + {{CpW{1'b0}}, 1'b1};
      end else begin
         len = '0;
      end
      return len;
   endfunction

endpackage

/* src/crt_tables.sv */
`timescale 1ns / 1ps
module crt_tables
   import crt_pkg::*;
#(
   parameter int DEPTH = 16,
   parameter int IW    = 4
) (
   input  logic            clock,
   input  logic            set1_we,
   input  logic            set2_we,
   input  logic [IW-1:0]   wr_addr,
   input  span_type        set1_wdata,
   input  entry_type       set2_wdata,
   input  logic [IW-1:0]   rd_addr,
   output span_type        set1_rdata,
   output entry_type       set2_rdata
);

   span_type  set1_mem [DEPTH];
   entry_type set2_mem [DEPTH];
   span_type  set1_rd_ff;
   entry_type set2_rd_ff;

   always_ff @(posedge clock) begin
      if (set1_we) begin
         set1_mem[wr_addr] <= set1_wdata;
      end
      set1_rd_ff <= set1_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (set2_we) begin
         set2_mem[wr_addr] <= set2_wdata;
      end
      set2_rd_ff <= set2_mem[rd_addr];
   end

   assign set1_rdata = set1_rd_ff;
   assign set2_rdata = set2_rd_ff;

endmodule

/* src/crt_divider.sv */
`timescale 1ns / 1ps
module crt_divider
   import crt_pkg::*;
#(
   parameter int DW = 27
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   input  logic [DW-1:0]   dividend,
   input  logic [RepW-1:0] divisor,
   output logic            done,
   output logic [DW-1:0]   quotient
);

   localparam int CntW = $clog2(DW + 1);

   logic [DW-1:0]   quo_ff, quo_in;
   logic [RepW-1:0] rem_ff, rem_in;
   logic [RepW-1:0] div_ff, div_in;
   logic [CntW-1:0] cnt_ff, cnt_in;
   logic            busy_ff, busy_in;
   logic            done_ff, done_in;
   logic [RepW:0]   shifted;
   logic [RepW:0]   trial;

   // restoring division, one quotient bit per cycle
   always_comb begin
      shifted = {rem_ff, quo_ff[DW-1]};
      trial   = shifted - {1'b0, div_ff};
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         div_in  = divisor;
         cnt_in  = CntW'(DW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[RepW]) begin
            rem_in = trial[RepW-1:0];
            quo_in = {quo_ff[DW-2:0], 1'b1};
         end else begin
            rem_in = shifted[RepW-1:0];
            quo_in = {quo_ff[DW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CntW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

/* src/char_range_translate.sv */
`timescale 1ns / 1ps
// character translate / delete / squeeze unit; load transactions (func 0 and 1) write one
// slot of the set-one range table or the set-two entry table; a translate transaction walks
// the set-one table entry by entry, a read state then an evaluate state, until a hit; on a
// hit with neither delete nor complement set, it walks the set-two table through read,
// multiply and compare states to find the target entry, then does a one-bit-per-cycle divide
// for repeated entries (27 quotient bits at 16 ranges); an emit state then hands the
// character to the output register and waits while a held result is stalled; both tables
// sit behind one read port with registered read data, which sets the walk pace; one
// transaction is in work at a time and a finished character waits in the output register
// while the next transaction is taken; tables are not cleared by reset and must be loaded
// before use
module char_range_translate
   import crt_pkg::*;
#(
   parameter int MAX_RANGES = 16
) (
   input  logic               clock,
   input  logic               reset,
   // request channel
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_func,
   input  logic [3:0]         req_table_index,
   input  logic [CpW-1:0]     req_range_first,
   input  logic [CpW-1:0]     req_range_last,
   input  logic [RepW-1:0]    req_repeat_count,
   input  logic [CpW-1:0]     req_char_in,
   // response channel
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [CpW-1:0]     rsp_char_out,
   // register write port
   input  logic               csr_write_enable,
   input  logic [CsrIdxW-1:0] csr_index,
   input  logic [CountW-1:0]  csr_write_data
);

   localparam int IW = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
   localparam int CW = $clog2(MAX_RANGES + 1);
   localparam int OW = CpW + 1 + CW;           // set-one offset
   localparam int LW = CpW + 1 + RepW;         // set-two entry length
   localparam int BW = LW + CW;                // set-two running base

   localparam logic [3:0] ST_IDLE    = 4'd0;
   localparam logic [3:0] ST_S1_RD   = 4'd1;
   localparam logic [3:0] ST_S1_EV   = 4'd2;
   localparam logic [3:0] ST_S2_RD   = 4'd3;
   localparam logic [3:0] ST_S2_MUL  = 4'd4;
   localparam logic [3:0] ST_S2_CMP  = 4'd5;
   localparam logic [3:0] ST_DIV     = 4'd6;
   localparam logic [3:0] ST_LAST_RD = 4'd7;
   localparam logic [3:0] ST_LAST_EV = 4'd8;
   localparam logic [3:0] ST_EMIT    = 4'd9;

   // configuration
   logic              cm_ff, dm_ff, sm_ff;
   logic [CountW-1:0] set1_count_ff, set2_count_ff;

   // control
   logic [3:0]     state_ff, state_in;
   logic [CW-1:0]  idx_ff, idx_in;
   logic [OW-1:0]  acc_ff, acc_in;            // set-one running offset, then the offset
   logic [BW-1:0]  base_ff, base_in;
   logic [LW-1:0]  len_ff, len_in;
   logic [CpW-1:0] char_ff, char_in;
   logic [CpW-1:0] val_ff, val_in;
   logic           sq_ff, sq_in;              // drop if equal to last emitted
   logic           nohit_ff, nohit_in;        // last-entry read for a set-one miss
   logic [CpW-1:0] last_ff, last_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [CpW-1:0] rsp_char_ff, rsp_char_in;

   logic [CW-1:0]  n1, n2;
   logic [8:0]     slot_ext;
   logic           slot_ok;
   logic           accept;
   logic [IW-1:0]  rd_addr;
   span_type       s1_rd;
   entry_type      s2_rd;
   logic           hit;
   logic           div_start;
   logic [OW-1:0]  div_dividend;
   logic           div_done;
   logic [OW-1:0]  div_quotient;
   logic [BW:0]    base_plus;

   assign n1 = ({4'b0, set1_count_ff} > 9'(MAX_RANGES)) ? CW'(MAX_RANGES) : CW'(set1_count_ff);
   assign n2 = ({4'b0, set2_count_ff} > 9'(MAX_RANGES)) ? CW'(MAX_RANGES) : CW'(set2_count_ff);

   assign slot_ext = {5'b0, req_table_index};
   assign slot_ok  = slot_ext < 9'(MAX_RANGES);
   assign accept   = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      case (state_ff)
         ST_S1_RD:   rd_addr = idx_ff[IW-1:0];
         ST_S2_RD, ST_S2_MUL, ST_S2_CMP: rd_addr = idx_ff[IW-1:0];
         ST_LAST_RD: rd_addr = IW'(n2 - 1'b1);
         default:    rd_addr = idx_ff[IW-1:0];
      endcase
   end

   crt_tables #(
      .DEPTH (MAX_RANGES),
      .IW    (IW)
   ) u_tables (
      .clock      (clock),
      .set1_we    (accept && slot_ok && req_func == FUNC_LOAD_SET1),
      .set2_we    (accept && slot_ok && req_func == FUNC_LOAD_SET2),
      .wr_addr    (slot_ext[IW-1:0]),
      .set1_wdata ('{first: req_range_first, last: req_range_last}),
      .set2_wdata ('{bounds: '{first: req_range_first, last: req_range_last},
                     rep: req_repeat_count}),
      .rd_addr    (rd_addr),
      .set1_rdata (s1_rd),
      .set2_rdata (s2_rd)
   );

   crt_divider #(
      .DW (OW)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (s2_rd.rep),
      .done     (div_done),
      .quotient (div_quotient)
   );

   assign hit          = (s1_rd.first <= char_ff) && (char_ff <= s1_rd.last);
   assign base_plus    = {1'b0, base_ff} + {{(CW + 1){1'b0}}, len_ff};
   assign div_dividend = acc_ff - OW'(base_ff);

   always_comb begin
      state_in  = state_ff;
      idx_in    = idx_ff;
      acc_in    = acc_ff;
      base_in   = base_ff;
      len_in    = len_ff;
      char_in   = char_ff;
      val_in    = val_ff;
      sq_in     = sq_ff;
      nohit_in  = nohit_ff;
      last_in   = last_ff;
      div_start = 1'b0;
      rsp_char_in  = rsp_char_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      case (state_ff)
         ST_IDLE: begin
            if (accept && req_func == FUNC_TRANSLATE) begin
               char_in = req_char_in;
               idx_in  = '0;
               acc_in  = '0;
               if (n1 != '0) begin
                  state_in = ST_S1_RD;
               end else if (cm_ff && n2 != '0) begin
                  nohit_in = 1'b1;
                  state_in = ST_LAST_RD;
               end else if (dm_ff && cm_ff) begin
                  state_in = ST_IDLE;
               end else begin
                  val_in   = req_char_in;
                  sq_in    = dm_ff && sm_ff;
                  state_in = ST_EMIT;
               end
            end
         end
         ST_S1_RD: state_in = ST_S1_EV;
         ST_S1_EV: begin
            if (hit) begin
               if (dm_ff) begin
                  if (!cm_ff) begin
                     state_in = ST_IDLE;
                  end else begin
                     val_in   = char_ff;
                     sq_in    = sm_ff;
                     state_in = ST_EMIT;
                  end
               end else if (cm_ff) begin
                  val_in   = char_ff;
                  sq_in    = 1'b0;
                  state_in = ST_EMIT;
               end else begin
                  acc_in = acc_ff + OW'(char_ff - s1_rd.first);
                  if (n2 == '0) begin
                     val_in   = char_ff;
                     sq_in    = sm_ff;
                     state_in = ST_EMIT;
                  end else begin
                     idx_in   = '0;
                     base_in  = '0;
                     state_in = ST_S2_RD;
                  end
               end
            end else begin
               acc_in = acc_ff + OW'(span_len(s1_rd));
               idx_in = idx_ff + 1'b1;
               if (idx_ff + 1'b1 == n1) begin
                  // set-one miss
                  if (cm_ff && n2 != '0) begin
                     nohit_in = 1'b1;
                     state_in = ST_LAST_RD;
                  end else if (dm_ff && cm_ff) begin
                     state_in = ST_IDLE;
                  end else begin
                     val_in   = char_ff;
                     sq_in    = dm_ff && sm_ff;
                     state_in = ST_EMIT;
                  end
               end else begin
                  state_in = ST_S1_RD;
               end
            end
         end
         ST_S2_RD: state_in = ST_S2_MUL;
         ST_S2_MUL: begin
            len_in   = span_len(s2_rd.bounds) * s2_rd.rep;
            state_in = ST_S2_CMP;
         end
         ST_S2_CMP: begin
            if (base_plus > {{(BW + 1 - OW){1'b0}}, acc_ff}) begin
               // offset lands in this entry, len > 0 so repeat is nonzero
               val_in    = s2_rd.bounds.first;
               div_start = 1'b1;
               state_in  = ST_DIV;
            end else begin
               base_in = base_plus[BW-1:0];
               idx_in  = idx_ff + 1'b1;
               if (idx_ff + 1'b1 == n2) begin
                  // offset beyond set two
                  nohit_in = 1'b0;
                  state_in = ST_LAST_RD;
               end else begin
                  state_in = ST_S2_RD;
               end
            end
         end
         ST_DIV: begin
            if (div_done) begin
               val_in   = val_ff + CpW'(div_quotient);
               sq_in    = sm_ff;
               state_in = ST_EMIT;
            end
         end
         ST_LAST_RD: state_in = ST_LAST_EV;
         ST_LAST_EV: begin
            val_in = s2_rd.bounds.last;
            if (nohit_ff) begin
               if (dm_ff && cm_ff) begin
                  state_in = ST_IDLE;
               end else begin
                  sq_in    = dm_ff && sm_ff;
                  state_in = ST_EMIT;
               end
            end else begin
               sq_in    = 1'b0;
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (sq_ff && val_ff == last_ff) begin
               state_in = ST_IDLE;
            end else if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = val_ff;
               last_in      = val_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_valid_ff  <= 1'b0;
         last_ff       <= '0;
         cm_ff         <= 1'b0;
         dm_ff         <= 1'b0;
         sm_ff         <= 1'b0;
         set1_count_ff <= '0;
         set2_count_ff <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         last_ff      <= last_in;
         if (csr_write_enable) begin
            case (csr_index)
               CSR_COMPLEMENT: cm_ff <= csr_write_data[0];
               CSR_DELETE:     dm_ff <= csr_write_data[0];
               CSR_SQUEEZE:    sm_ff <= csr_write_data[0];
               CSR_SET1_COUNT: set1_count_ff <= csr_write_data;
               CSR_SET2_COUNT: set2_count_ff <= csr_write_data;
               default: ;
            endcase
         end
      end
      idx_ff      <= idx_in;
      acc_ff      <= acc_in;
      base_ff     <= base_in;
      len_ff      <= len_in;
      char_ff     <= char_in;
      val_ff      <= val_in;
      sq_ff       <= sq_in;
      nohit_ff    <= nohit_in;
      rsp_char_ff <= rsp_char_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_char_out = rsp_char_ff;

endmodule
